@@ rtl/bts_pkg.sv @@
// bts_pkg: shared types and constants for the BER-TLV tag seek block.
// Transaction payload structs, parser phase enum, parser state record.
// No dependencies.
package bts_pkg;

	localparam int unsigned TAG_W = 24;
	localparam int unsigned POS_W = 16;

	localparam logic [7:0] TAG_MORE_MASK = 8'h1F;  // low five bits set: tag continues
	localparam logic [7:0] HIGH_BIT      = 8'h80;  // tag continues / long length form
	localparam logic [7:0] LEN_LONG_ONE  = 8'h81;  // one length byte follows
	localparam logic [7:0] LEN_LONG_TWO  = 8'h82;  // two length bytes follow

	typedef enum logic [2:0] {
		PH_TAG1  = 3'd0,
		PH_TAG2  = 3'd1,
		PH_TAG3  = 3'd2,
		PH_LEN1  = 3'd3,
		PH_LENX  = 3'd4,
		PH_VALUE = 3'd5,
		PH_SKIP  = 3'd6
	} bts_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} bts_in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_offset;
	} bts_out_t;

	typedef struct packed {
		bts_phase_t       phase;
		logic [TAG_W-1:0] tag_accum;
		logic [POS_W-1:0] element_start;
		logic [POS_W-1:0] byte_position;
		logic [POS_W-1:0] value_remaining;
		logic [1:0]       length_left;
		logic             done;
	} bts_state_t;

	localparam bts_state_t STATE_RESET = '{
		phase:           PH_TAG1,
		tag_accum:       '0,
		element_start:   '0,
		byte_position:   '0,
		value_remaining: '0,
		length_left:     '0,
		done:            1'b0
	};

endpackage

@@ rtl/ber_tlv_tag_seek.sv @@
// ber_tlv_tag_seek: top level of the BER-TLV tag search block.
// Input register, parser, result register and target tag register.
// Depends on bts_pkg and bts_parse.

// The block reads a BER-TLV list one byte per transaction (last_byte marks the
// final byte) and reports the first element whose tag equals target_tag:
// found=1 with the offset of that element's first tag byte, or, if the list
// ends without a match, a single found=0 transaction with offset 0. Later
// bytes of a list after a match give nothing. Tags are 1 to 3 bytes; lengths
// are short form, 0x81 or 0x82; any other long form makes the rest of the list
// be skipped. Throughput is one byte per clock while the result side does not
// stall: the accepted byte sits in the input register, the parser decides it
// combinationally and the result register takes the outcome when the parser
// steps; out_data is driven from that register. The only thing that
// slows input is a stall on the result side while a result is waiting, which
// holds the input register. target_tag is written through cfg_we/cfg_wdata;
// the user must do so only while the block is idle, which the block does not
// enforce. It resets to 0. No memories, so no post-reset clearing time.
module ber_tlv_tag_seek #(
	parameter int unsigned LIST_MAX_BYTES = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// byte input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bts_pkg::bts_in_t          in_data,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output bts_pkg::bts_out_t         out_data,
	// target tag register write
	input  logic                      cfg_we,
	input  logic [bts_pkg::TAG_W-1:0] cfg_wdata
);
	import bts_pkg::*;

	bts_in_t          in_s1;
	logic             in_vld_s1;
	bts_out_t         out_q;
	logic             out_vld_q;
	logic [TAG_W-1:0] target_tag_q;

	logic             step;
	logic             accept;
	logic             emit;
	bts_out_t         result;

	// parser advances on a held byte whenever the result register is free or draining
	assign step     = in_vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = in_vld_s1 && !step;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_tag_q <= '0;
		end else if (cfg_we) begin
			target_tag_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (accept) begin
			in_vld_s1 <= 1'b1;
		end else if (step) begin
			in_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= in_data;
		end
	end

	bts_parse #(
		.LIST_MAX_BYTES(LIST_MAX_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (in_s1),
		.target_tag(target_tag_q),
		.emit      (emit),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step && emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= result;
		end
	end

`ifndef SYNTH
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.match_offset == '0)
		else $error("not-found result with nonzero offset");

	a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_vld_s1 && out_vld_q && out_stall)
		else $error("input stalled without a blocked result");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> out_valid)
		else $error("emitted result not presented");

	a_byte_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		step && !accept |=> !in_vld_s1)
		else $error("input register not released after step");
`endif

endmodule

@@ rtl/bts_parse.sv @@
// bts_parse: BER-TLV parser state and per-byte next-state logic.
// Consumes one byte per step cycle, flags a result transaction when one is due.
// Depends on bts_pkg.
module bts_parse #(
	parameter int unsigned LIST_MAX_BYTES = 65535
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  bts_pkg::bts_in_t              byte_in,
	input  logic [bts_pkg::TAG_W-1:0]     target_tag,
	output logic                          emit,
	output bts_pkg::bts_out_t             result
);
	import bts_pkg::*;

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LIST_MAX_BYTES);

	bts_state_t       st_q;
	bts_state_t       nxt;
	bts_state_t       upd;
	logic             match;
	logic             in_range;
	logic [7:0]       b;
	logic [1:0]       left_dec;
	logic [POS_W-1:0] val_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step) begin
			st_q <= nxt;
		end
	end

	always_comb begin
		b         = byte_in.data_byte;
		in_range  = st_q.byte_position < POS_LIMIT;
		match     = 1'b0;
		upd       = st_q;
		left_dec  = st_q.length_left - 2'd1;
		val_shift = {st_q.value_remaining[7:0], b};

		if (!st_q.done && in_range) begin
			case (st_q.phase)
				PH_TAG1: begin
					upd.element_start = st_q.byte_position;
					upd.tag_accum     = {16'h0000, b};
					if ((b & TAG_MORE_MASK) == TAG_MORE_MASK) begin
						upd.phase = PH_TAG2;
					end else if ({16'h0000, b} == target_tag) begin
						match = 1'b1;
					end else begin
						upd.phase = PH_LEN1;
					end
				end
				PH_TAG2: begin
					upd.tag_accum = {st_q.tag_accum[15:0], b};
					if ((b & HIGH_BIT) != 8'h00) begin
						upd.phase = PH_TAG3;
					end else if ({st_q.tag_accum[15:0], b} == target_tag) begin
						match = 1'b1;
					end else begin
						upd.phase = PH_LEN1;
					end
				end
				PH_TAG3: begin
					upd.tag_accum = {st_q.tag_accum[15:0], b};
					if ({st_q.tag_accum[15:0], b} == target_tag) begin
						match = 1'b1;
					end else begin
						upd.phase = PH_LEN1;
					end
				end
				PH_LEN1: begin
					if ((b & HIGH_BIT) == 8'h00) begin
						upd.value_remaining = {8'h00, b};
						upd.phase = (b == 8'h00) ? PH_TAG1 : PH_VALUE;
					end else if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
						upd.value_remaining = '0;
						upd.length_left     = (b == LEN_LONG_ONE) ? 2'd1 : 2'd2;
						upd.phase           = PH_LENX;
					end else begin
						// unsupported long form: rest of the list is skipped
						upd.phase = PH_SKIP;
					end
				end
				PH_LENX: begin
					upd.value_remaining = val_shift;
					upd.length_left     = left_dec;
					if (left_dec == 2'd0) begin
						upd.phase = (val_shift == '0) ? PH_TAG1 : PH_VALUE;
					end
				end
				PH_VALUE: begin
					upd.value_remaining = st_q.value_remaining - POS_W'(1);
					if (st_q.value_remaining == POS_W'(1)) begin
						upd.phase = PH_TAG1;
					end
				end
				default: begin
					upd.phase = PH_SKIP;
				end
			endcase
		end

		if (match) begin
			upd.done = 1'b1;
		end
		if (in_range) begin
			upd.byte_position = st_q.byte_position + POS_W'(1);
		end

		// result: match now, or end of list with no match so far
		emit                = match || (byte_in.last_byte && !upd.done);
		result.found        = match;
		result.match_offset = match ? upd.element_start : '0;

		nxt = byte_in.last_byte ? STATE_RESET : upd;
	end

endmodule

@@ tb/ber_tlv_tag_seek_tb.sv @@
`timescale 1ns / 1ps
// ber_tlv_tag_seek_tb: self-checking testbench for the BER-TLV tag seek block.
// Byte driver, result monitor and a transaction-level predictor of the search.
// Depends on bts_pkg and ber_tlv_tag_seek.
module ber_tlv_tag_seek_tb;
	import bts_pkg::*;

	localparam int unsigned LIST_MAX       = 65535;
	localparam int unsigned RAND_PER_PHASE = 110;  // random bytes per target setting
	localparam int unsigned DRAIN_CYCLES   = 8;    // pipeline is two deep; margin on top

	typedef logic [7:0] byte_list_t[$];
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	bts_in_t          in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	bts_out_t         out_data;
	logic             cfg_we    = 1'b0;
	logic [TAG_W-1:0] cfg_wdata = '0;

	ber_tlv_tag_seek #(
		.LIST_MAX_BYTES(LIST_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Search predictor: its own copy of the target register and parser
	// state, advanced once per accepted byte transaction.
	// ------------------------------------------------------------------
	logic [TAG_W-1:0] p_target = '0;
	bts_phase_t       p_phase;
	logic [TAG_W-1:0] p_tag;
	logic [POS_W-1:0] p_start;
	logic [POS_W-1:0] p_pos;      // saturates at LIST_MAX
	logic [POS_W-1:0] p_vrem;     // value bytes still to skip
	logic [1:0]       p_lenleft;  // long-form length bytes still to come
	logic             p_done;     // match already reported for this list

	bts_in_t  list_bytes_q[$];      // bytes waiting for the driver
	bts_out_t seek_results_due[$];  // predicted results, oldest first
	int       mismatches = 0;

	function automatic void clear_list_state();
		p_phase   = PH_TAG1;
		p_tag     = '0;
		p_start   = '0;
		p_pos     = '0;
		p_vrem    = '0;
		p_lenleft = '0;
		p_done    = 1'b0;
	endfunction

	task automatic predict_seek(input bts_in_t item);
		logic [7:0] b;
		bit         tag_end;
		b       = item.data_byte;
		tag_end = 1'b0;
		if (!p_done && p_pos < LIST_MAX) begin
			case (p_phase)
			PH_TAG1: begin
				p_start = p_pos;
				p_tag   = {16'h0, b};
				if ((b & TAG_MORE_MASK) == TAG_MORE_MASK) p_phase = PH_TAG2;
				else tag_end = 1'b1;
			end
			PH_TAG2: begin
				p_tag = {p_tag[15:0], b};
				if ((b & HIGH_BIT) != '0) p_phase = PH_TAG3;
				else tag_end = 1'b1;
			end
			PH_TAG3: begin
				p_tag   = {p_tag[15:0], b};
				tag_end = 1'b1;
			end
			PH_LEN1: begin
				if ((b & HIGH_BIT) == '0) begin
					p_vrem  = {8'h0, b};
					p_phase = (b == '0) ? PH_TAG1 : PH_VALUE;
				end else if (b == LEN_LONG_ONE || b == LEN_LONG_TWO) begin
					p_vrem    = '0;
					p_lenleft = (b == LEN_LONG_ONE) ? 2'd1 : 2'd2;
					p_phase   = PH_LENX;
				end else begin
					// unsupported long form: rest of the list is dead
					p_phase = PH_SKIP;
				end
			end
			PH_LENX: begin
				p_vrem    = {p_vrem[7:0], b};
				p_lenleft = p_lenleft - 2'd1;
				if (p_lenleft == 2'd0) p_phase = (p_vrem == '0) ? PH_TAG1 : PH_VALUE;
			end
			PH_VALUE: begin
				p_vrem = p_vrem - 1'b1;
				if (p_vrem == '0) p_phase = PH_TAG1;
			end
			default: p_phase = PH_SKIP;
			endcase
			// the tag is compared as soon as its last byte is in
			if (tag_end) begin
				if (p_tag == p_target) begin
					seek_results_due.push_back(bts_out_t'{found: 1'b1, match_offset: p_start});
					p_done = 1'b1;
				end else begin
					p_phase = PH_LEN1;
				end
			end
		end
		if (p_pos < LIST_MAX) p_pos = p_pos + 1'b1;
		if (item.last_byte) begin
			if (!p_done) seek_results_due.push_back(bts_out_t'{found: 1'b0, match_offset: '0});
			clear_list_state();
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// a target is reachable only if it is a legal 1, 2 or 3 byte encoding
	function automatic bit tag_ok(input logic [TAG_W-1:0] t);
		if (t[23:16] != '0) return (t[23:16] & TAG_MORE_MASK) == TAG_MORE_MASK && t[15];
		if (t[15:8] != '0) return (t[15:8] & TAG_MORE_MASK) == TAG_MORE_MASK && !t[7];
		return (t[7:0] & TAG_MORE_MASK) != TAG_MORE_MASK;
	endfunction

	function automatic logic [TAG_W-1:0] rand_tag();
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		case ($urandom_range(1, 3))
		1: begin
			if ((b0 & TAG_MORE_MASK) == TAG_MORE_MASK) b0[0] = 1'b0;
			return {16'h0, b0};
		end
		2: return {8'h0, b0 | TAG_MORE_MASK, b1 & ~HIGH_BIT};
		default: return {b0 | TAG_MORE_MASK, b1 | HIGH_BIT, b2};
		endcase
	endfunction

	// one list: mostly well-formed elements, the target tag planted now and
	// then; some lists hit a bad long form, get cut short, or are pure noise
	function automatic byte_list_t random_list(input logic [TAG_W-1:0] want);
		byte_list_t       lst;
		logic [TAG_W-1:0] t;
		int               vlen;
		int               form;
		int               n_elem;
		n_elem = $urandom_range(1, 6);
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 8)) lst.push_back(8'($urandom));
			return lst;
		end
		for (int e = 0; e < n_elem; e++) begin
			t = (tag_ok(want) && $urandom_range(0, 3) == 0) ? want : rand_tag();
			if (t[23:16] != '0) lst.push_back(t[23:16]);
			if (t[23:8] != '0) lst.push_back(t[15:8]);
			lst.push_back(t[7:0]);
			form = $urandom_range(0, 15);
			vlen = $urandom_range(0, 5);
			if (form == 15) begin
				lst.push_back($urandom_range(0, 1) ? HIGH_BIT : 8'($urandom_range(8'h83, 8'hFF)));
				vlen = $urandom_range(0, 4);
			end else if (form < 9) begin
				lst.push_back(8'(vlen));
			end else if (form == 9) begin
				vlen = $urandom_range(0, 127);
				lst.push_back(8'(vlen));
			end else if (form < 12) begin
				if (form == 11) vlen = $urandom_range(0, 255);
				lst.push_back(LEN_LONG_ONE);
				lst.push_back(8'(vlen));
			end else begin
				if (form == 14) vlen = $urandom_range(256, 300);
				lst.push_back(LEN_LONG_TWO);
				lst.push_back(8'(vlen >> 8));
				lst.push_back(8'(vlen));
			end
			repeat (vlen) lst.push_back(8'($urandom));
		end
		if ($urandom_range(0, 5) == 0) lst = lst[0:$urandom_range(0, lst.size() - 1)];
		return lst;
	endfunction

	task automatic queue_list(input byte_list_t bytes);
		foreach (bytes[i])
			list_bytes_q.push_back(bts_in_t'{data_byte: bytes[i],
				last_byte: (i == bytes.size() - 1)});
	endtask

	// target register is only touched with the pipeline empty
	task automatic write_target(input logic [TAG_W-1:0] t);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we   <= 1'b0;
		p_target = t;
	endtask

	// sender holds off until every predicted result is back, then the
	// pipeline is given time to drain bytes that produce nothing
	task automatic wait_drained();
		do @(negedge clk);
		while (list_bytes_q.size() != 0 || in_valid || seek_results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of random length with random gaps, some long runs with
	// no gap at all. Prediction happens on the accepting edge.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (in_valid && !in_stall) predict_seek(in_data);
			// payload may only move once the current transaction is taken
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (list_bytes_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data  <= list_bytes_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side stall: none, light, heavy or periodic, re-picked at random.
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	logic [7:0]  stall_tick = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode <= STALL_NONE;
			mode_left  <= 0;
			stall_tick <= '0;
		end else begin
			stall_tick <= stall_tick + 8'd1;
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_tick[2];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each accepted result against the oldest prediction
	// ------------------------------------------------------------------
	bts_out_t want_res;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (seek_results_due.size() == 0) begin
				$display("%0t: unexpected result, got found=%0b offset=%0d",
					$time, out_data.found, out_data.match_offset);
				mismatches++;
			end else begin
				want_res = seek_results_due.pop_front();
				if (out_data.found !== want_res.found) begin
					$display("%0t: found expected %0b, got %0b",
						$time, want_res.found, out_data.found);
					mismatches++;
				end
				if (out_data.match_offset !== want_res.match_offset) begin
					$display("%0t: match_offset expected %0d, got %0d",
						$time, want_res.match_offset, out_data.match_offset);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed lists, then random phases over several targets
	// ------------------------------------------------------------------
	initial begin
		logic [TAG_W-1:0] tgt;
		byte_list_t       lst;
		int               queued;
		clear_list_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// target still at its reset value 0; match lands on the final byte
		queue_list('{8'h01, 8'h01, 8'hAA, 8'h00});
		wait_drained();

		write_target(24'hDF8F7F);
		// 2-byte miss, 0x81 length, then 3-byte match at 5 and a trailing byte
		queue_list('{8'h9F, 8'h01, 8'h81, 8'h01, 8'hFF, 8'hDF, 8'h8F, 8'h7F, 8'h00});
		// tag cut off by end of list
		queue_list('{8'h1F, 8'h81});
		// 0x80 length: the matching tag after it is never parsed
		queue_list('{8'h02, 8'h80, 8'hDF, 8'h8F, 8'h7F});
		// two-byte length cut off
		queue_list('{8'h02, 8'h82, 8'h00});
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			if (p == 0) tgt = '0;
			else if (p == 1) tgt = '1;
			else if (p < 8) tgt = rand_tag();
			else tgt = TAG_W'($urandom);  // usually not a legal encoding
			write_target(tgt);
			queued = 0;
			while (queued < RAND_PER_PHASE) begin
				lst = random_list(tgt);
				queue_list(lst);
				queued += lst.size();
			end
			wait_drained();
		end

		if (mismatches == 0 && seek_results_due.size() == 0) begin
			$display("[ber_tlv_tag_seek] OK");
		end else begin
			$display("[ber_tlv_tag_seek] ERROR");
		end
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#40_000_000;
		$display("[ber_tlv_tag_seek] ERROR");
		$finish;
	end

endmodule
